FILE: hw/rtl/hdu_pkg.sv
package hdu_pkg;

	localparam int DATA_BITS_DEF = 8;
	localparam int CFG_INDEX_W   = 2;
	localparam int CFG_DATA_W    = 8;

	// register indexes on the configuration channel
	localparam logic [CFG_INDEX_W-1:0] REG_RX_HALF_BIT = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_RX_BIT      = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_TX_BIT      = 2'd2;

	localparam logic [7:0] RX_HALF_BIT_RESET = 8'd52;
	localparam logic [7:0] RX_BIT_RESET      = 8'd103;
	localparam logic [7:0] TX_BIT_RESET      = 8'd103;

	typedef struct packed {
		logic       rx_level;
		logic       tx_request;
		logic [7:0] tx_byte;
		logic       tx_last;
	} tick_t;

	typedef struct packed {
		logic       tx_level;
		logic       rx_valid;
		logic [7:0] rx_byte;
		logic       tx_accepted;
		logic [2:0] line_mode;
	} result_t;

	typedef struct packed {
		logic [CFG_INDEX_W-1:0] index;
		logic [CFG_DATA_W-1:0]  data;
	} cfg_t;

endpackage

FILE: hw/rtl/hdu_chan_if.sv
interface hdu_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/half_duplex_uart_8n1.sv
// Half-duplex 8N1 UART, one prescaled timer tick per request.
// The result of a tick is registered and shows in the cycle after it is accepted.
// Throughput: one tick per cycle while results are taken; the output register frees as it is taken.
// Reset (arst_n low, asynchronous): idle mode, line released high, bit
// timing compares back to 52 / 103 / 103.
module half_duplex_uart_8n1 #(
	parameter int DATA_BITS = hdu_pkg::DATA_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	hdu_chan_if.sink   tick,
	hdu_chan_if.source result,
	hdu_chan_if.sink   cfg
);
	import hdu_pkg::*;

	localparam int FRAME_BITS = DATA_BITS + 2;

	localparam logic [2:0] MODE_IDLE    = 3'd0;
	localparam logic [2:0] MODE_RX_WAIT = 3'd1;
	localparam logic [2:0] MODE_RX_DATA = 3'd2;
	localparam logic [2:0] MODE_TX      = 3'd3;
	localparam logic [2:0] MODE_TX_HOLD = 3'd4;

	localparam logic [3:0] RX_LAST_BIT = 4'(DATA_BITS - 1);
	localparam logic [3:0] TX_LAST_BIT = 4'(FRAME_BITS - 1);

	logic [7:0] rx_half_cmp_q, rx_bit_cmp_q, tx_bit_cmp_q;

	logic [2:0]            mode_q, mode_d;
	logic [7:0]            tick_count_q, tick_count_d;
	logic [3:0]            bit_count_q, bit_count_d;
	logic [DATA_BITS-1:0]  rx_shift_q, rx_shift_d;
	logic [FRAME_BITS-1:0] tx_shift_q, tx_shift_d;
	logic                  prev_rx_q;
	logic                  burst_last_q, burst_last_d;

	logic    res_valid_q;
	result_t res_q, res_d;

	tick_t                 t;
	logic                  accept;
	logic                  falling;
	logic [DATA_BITS+7:0]  byte_ext;
	logic [DATA_BITS+7:0]  rx_ext;

	assign t          = tick.payload;
	assign tick.ready = !res_valid_q || result.ready;
	assign accept     = tick.valid && tick.ready;
	assign falling    = prev_rx_q && !t.rx_level;
	assign byte_ext   = {{DATA_BITS{1'b0}}, t.tx_byte};

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_half_cmp_q <= RX_HALF_BIT_RESET;
			rx_bit_cmp_q  <= RX_BIT_RESET;
			tx_bit_cmp_q  <= TX_BIT_RESET;
		end else if (cfg.valid) begin
			case (cfg.payload.index)
				REG_RX_HALF_BIT: rx_half_cmp_q <= cfg.payload.data;
				REG_RX_BIT:      rx_bit_cmp_q  <= cfg.payload.data;
				REG_TX_BIT:      tx_bit_cmp_q  <= cfg.payload.data;
				default: ;
			endcase
		end
	end

	always_comb begin
		mode_d       = mode_q;
		tick_count_d = tick_count_q;
		bit_count_d  = bit_count_q;
		rx_shift_d   = rx_shift_q;
		tx_shift_d   = tx_shift_q;
		burst_last_d = burst_last_q;
		res_d        = '0;

		case (mode_q)
			MODE_IDLE, MODE_TX_HOLD: begin
				if (t.tx_request) begin
					res_d.tx_accepted = 1'b1;
					burst_last_d      = t.tx_last;
					tx_shift_d        = {1'b1, byte_ext[DATA_BITS-1:0], 1'b0};
					tick_count_d      = '0;
					bit_count_d       = '0;
					mode_d            = MODE_TX;
				end else if (mode_q == MODE_IDLE && falling) begin
					tick_count_d = '0;
					bit_count_d  = '0;
					mode_d       = MODE_RX_WAIT;
				end
			end
			MODE_RX_WAIT: begin
				if (tick_count_q == rx_half_cmp_q) begin
					tick_count_d = '0;
					mode_d       = MODE_RX_DATA;
				end else begin
					tick_count_d = tick_count_q + 8'd1;
				end
			end
			MODE_RX_DATA: begin
				if (tick_count_q == rx_bit_cmp_q) begin
					tick_count_d = '0;
					rx_shift_d   = {t.rx_level, rx_shift_q[DATA_BITS-1:1]};
					bit_count_d  = bit_count_q + 4'd1;
					if (bit_count_q >= RX_LAST_BIT) begin
						bit_count_d    = '0;
						res_d.rx_valid = 1'b1;
						mode_d         = MODE_IDLE;
					end
				end else begin
					tick_count_d = tick_count_q + 8'd1;
				end
			end
			MODE_TX: begin
				if (tick_count_q == tx_bit_cmp_q) begin
					tick_count_d = '0;
					tx_shift_d   = {1'b1, tx_shift_q[FRAME_BITS-1:1]};
					bit_count_d  = bit_count_q + 4'd1;
					if (bit_count_q >= TX_LAST_BIT) begin
						bit_count_d = '0;
						tx_shift_d  = '1;
						mode_d      = burst_last_q ? MODE_IDLE : MODE_TX_HOLD;
					end
				end else begin
					tick_count_d = tick_count_q + 8'd1;
				end
			end
			default: begin
				mode_d       = MODE_IDLE;
				tick_count_d = '0;
				bit_count_d  = '0;
				tx_shift_d   = '1;
			end
		endcase

		// received byte shows only on the completing tick
		rx_ext        = {8'd0, rx_shift_d};
		res_d.rx_byte = res_d.rx_valid ? rx_ext[7:0] : 8'd0;

		res_d.tx_level  = (mode_d == MODE_TX) ? tx_shift_d[0] : 1'b1;
		res_d.line_mode = mode_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_IDLE;
			tick_count_q <= '0;
			bit_count_q  <= '0;
			rx_shift_q   <= '0;
			tx_shift_q   <= '1;
			prev_rx_q    <= 1'b1;
			burst_last_q <= 1'b0;
		end else if (accept) begin
			mode_q       <= mode_d;
			tick_count_q <= tick_count_d;
			bit_count_q  <= bit_count_d;
			rx_shift_q   <= rx_shift_d;
			tx_shift_q   <= tx_shift_d;
			prev_rx_q    <= t.rx_level;
			burst_last_q <= burst_last_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (tick.ready) begin
			res_valid_q <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_d;
		end
	end

	assign result.valid   = res_valid_q;
	assign result.payload = res_q;

endmodule

FILE: test/uart_line_checker.sv
`timescale 1ns / 1ps

module uart_line_checker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            tick_valid,
	input  logic            tick_ready,
	input  hdu_pkg::tick_t   tick_data,
	input  logic            result_valid,
	input  logic            result_ready,
	input  hdu_pkg::result_t result_data,
	input  logic            cfg_valid,
	input  logic            cfg_ready,
	input  hdu_pkg::cfg_t    cfg_data,
	output int              fail_count,
	output int              outstanding
);
	import hdu_pkg::*;

	localparam int DBITS      = DATA_BITS_DEF;
	localparam int FRAME_BITS = DBITS + 2;

	typedef enum logic [2:0] {
		LM_IDLE,
		LM_RX_WAIT,
		LM_RX_DATA,
		LM_TX,
		LM_TX_HOLD
	} line_mode_e;

	logic [7:0]            half_cmp;
	logic [7:0]            rx_cmp;
	logic [7:0]            tx_cmp;
	line_mode_e            lm;
	logic [7:0]            tick_cnt;
	logic [3:0]            bit_cnt;
	logic [DBITS-1:0]      rx_shift;
	logic [FRAME_BITS-1:0] tx_shift;
	logic                  prev_lvl;
	logic                  burst_last;
	result_t               line_results_q[$];

	// advance the line state by one timer tick and return what the block shows
	function automatic result_t advance_line(tick_t t);
		result_t    r;
		line_mode_e entry;
		logic       falling;
		r       = '0;
		entry   = lm;
		falling = prev_lvl && !t.rx_level;
		case (entry)
			LM_IDLE, LM_TX_HOLD: begin
				if (t.tx_request) begin
					r.tx_accepted = 1'b1;
					burst_last    = t.tx_last;
					tx_shift      = {1'b1, t.tx_byte, 1'b0};
					tick_cnt      = '0;
					bit_cnt       = '0;
					lm            = LM_TX;
				end else if (entry == LM_IDLE && falling) begin
					tick_cnt = '0;
					bit_cnt  = '0;
					lm       = LM_RX_WAIT;
				end
			end
			LM_RX_WAIT: begin
				if (tick_cnt == half_cmp) begin
					tick_cnt = '0;
					lm       = LM_RX_DATA;
				end else begin
					tick_cnt = tick_cnt + 8'd1;
				end
			end
			LM_RX_DATA: begin
				if (tick_cnt == rx_cmp) begin
					tick_cnt = '0;
					rx_shift = {t.rx_level, rx_shift[DBITS-1:1]};
					bit_cnt  = bit_cnt + 4'd1;
					if (bit_cnt >= DBITS) begin
						bit_cnt    = '0;
						r.rx_valid = 1'b1;
						r.rx_byte  = rx_shift[7:0];
						lm         = LM_IDLE;
					end
				end else begin
					tick_cnt = tick_cnt + 8'd1;
				end
			end
			LM_TX: begin
				if (tick_cnt == tx_cmp) begin
					tick_cnt = '0;
					tx_shift = {1'b1, tx_shift[FRAME_BITS-1:1]};
					bit_cnt  = bit_cnt + 4'd1;
					if (bit_cnt >= FRAME_BITS) begin
						bit_cnt  = '0;
						tx_shift = '1;
						lm       = burst_last ? LM_IDLE : LM_TX_HOLD;
					end
				end else begin
					tick_cnt = tick_cnt + 8'd1;
				end
			end
			default: begin
				lm       = LM_IDLE;
				tick_cnt = '0;
				bit_cnt  = '0;
				tx_shift = '1;
			end
		endcase
		prev_lvl    = t.rx_level;
		r.tx_level  = (lm == LM_TX) ? tx_shift[0] : 1'b1;
		r.line_mode = lm;
		return r;
	endfunction

	task automatic check_field(string what, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			half_cmp   = RX_HALF_BIT_RESET;
			rx_cmp     = RX_BIT_RESET;
			tx_cmp     = TX_BIT_RESET;
			lm         = LM_IDLE;
			tick_cnt   = '0;
			bit_cnt    = '0;
			rx_shift   = '0;
			tx_shift   = '1;
			prev_lvl   = 1'b1;
			burst_last = 1'b0;
			line_results_q.delete();
			fail_count  = 0;
			outstanding = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_data.index)
					REG_RX_HALF_BIT: half_cmp = cfg_data.data;
					REG_RX_BIT:      rx_cmp   = cfg_data.data;
					REG_TX_BIT:      tx_cmp   = cfg_data.data;
					default: ;
				endcase
			end
			if (tick_valid && tick_ready)
				line_results_q.push_back(advance_line(tick_data));
			if (result_valid && result_ready) begin
				if (line_results_q.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result, expected none, got %h",
						$time, result_data);
				end else begin
					want = line_results_q.pop_front();
					check_field("tx_level", 8'(want.tx_level), 8'(result_data.tx_level));
					check_field("rx_valid", 8'(want.rx_valid), 8'(result_data.rx_valid));
					check_field("rx_byte", want.rx_byte, result_data.rx_byte);
					check_field("tx_accepted", 8'(want.tx_accepted),
						8'(result_data.tx_accepted));
					check_field("line_mode", 8'(want.line_mode), 8'(result_data.line_mode));
				end
			end
			outstanding = line_results_q.size();
		end
	end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import hdu_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASES      = 7;

	// timing settings per phase, listed in register index order
	localparam logic [7:0] PH_SET [PHASES][3] = '{
		'{RX_HALF_BIT_RESET, RX_BIT_RESET, TX_BIT_RESET},
		'{8'd0, 8'd0, 8'd0},
		'{8'd1, 8'd3, 8'd2},
		'{8'd2, 8'd5, 8'd3},
		'{8'd255, 8'd255, 8'd255},
		'{8'd0, 8'd1, 8'd0},
		'{8'd3, 8'd7, 8'd1}
	};
	localparam int PH_ITEMS [PHASES] = '{90, 200, 220, 220, 300, 160, 160};
	localparam logic [CFG_INDEX_W-1:0] CFG_ORDER [3] = '{REG_RX_HALF_BIT, REG_RX_BIT, REG_TX_BIT};

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	int    cycles = 0;
	int    fail_count;
	int    outstanding;
	bit    tx_quiet = 1'b0;
	bit    rx_quiet = 1'b0;
	bit    hold_results = 1'b0;
	tick_t plan[$];

	hdu_chan_if #(.payload_t(tick_t))   tick_ch ();
	hdu_chan_if #(.payload_t(result_t)) result_ch ();
	hdu_chan_if #(.payload_t(cfg_t))    cfg_ch ();

	half_duplex_uart_8n1 u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	uart_line_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.tick_valid   (tick_ch.valid),
		.tick_ready   (tick_ch.ready),
		.tick_data    (tick_ch.payload),
		.result_valid (result_ch.valid),
		.result_ready (result_ch.ready),
		.result_data  (result_ch.payload),
		.cfg_valid    (cfg_ch.valid),
		.cfg_ready    (cfg_ch.ready),
		.cfg_data     (cfg_ch.payload),
		.fail_count   (fail_count),
		.outstanding  (outstanding)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic tick_t line_tick(logic lvl, logic req, logic [7:0] data, logic last);
		tick_t t;
		t.rx_level   = lvl;
		t.tx_request = req;
		t.tx_byte    = data;
		t.tx_last    = last;
		return t;
	endfunction

	task automatic wait_drained();
		do @(negedge clk); while (outstanding != 0);
	endtask

	// result side: random stalls, plus one long hold-off to back up the input
	initial begin
		int gap;
		result_ch.ready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 31) == 0)
				rx_quiet = !rx_quiet;
			gap = rx_quiet ? 0 : $urandom_range(0, 15);
			if (hold_results) begin
				hold_results = 1'b0;
				gap = 400;
			end
			if (gap > 0) begin
				result_ch.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!result_ch.valid);
		end
	end

	initial begin
		tick_t      item;
		int         sent;
		int         gap;
		int         burst;
		int         rx_span;
		int         tx_span;
		logic [9:0] frame;
		tick_ch.valid   = 1'b0;
		tick_ch.payload = '0;
		cfg_ch.valid    = 1'b0;
		cfg_ch.payload  = '0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int p = 0; p < PHASES; p++) begin
			// phase 0 runs on the reset timing
			if (p > 0) begin
				for (int r = 0; r < 3; r++) begin
					cfg_ch.payload <= {CFG_ORDER[r], PH_SET[p][r]};
					cfg_ch.valid   <= 1'b1;
					do @(posedge clk); while (!cfg_ch.ready);
					@(negedge clk);
				end
				cfg_ch.valid <= 1'b0;
			end
			rx_span = int'(PH_SET[p][REG_RX_BIT]) + 1;
			tx_span = int'(PH_SET[p][REG_TX_BIT]) + 1;

			if (p == 1) begin
				plan.push_back(line_tick(1'b1, 1'b0, 8'hFF, 1'b1));
				plan.push_back(line_tick(1'b0, 1'b0, 8'h00, 1'b0));
				// request during reception is dropped
				plan.push_back(line_tick(1'b0, 1'b1, 8'h5A, 1'b1));
				// last data bit low, and the line stays low through the stop bit
				for (int i = 0; i < 8; i++)
					plan.push_back(line_tick(i != 7, 1'b0, 8'h00, 1'b0));
				plan.push_back(line_tick(1'b0, 1'b0, 8'h00, 1'b0));
				plan.push_back(line_tick(1'b1, 1'b0, 8'h00, 1'b0));
				// falling edge and request on the same tick: the send wins
				plan.push_back(line_tick(1'b0, 1'b1, 8'h00, 1'b0));
				plan.push_back(line_tick(1'b1, 1'b1, 8'hFF, 1'b1));
				for (int i = 0; i < 9; i++)
					plan.push_back(line_tick(i[0], 1'b0, 8'h00, 1'b0));
				// not the last byte: the falling edge in hold is ignored
				plan.push_back(line_tick(1'b1, 1'b0, 8'h00, 1'b0));
				plan.push_back(line_tick(1'b0, 1'b0, 8'h00, 1'b0));
			end
			if (p == 2)
				hold_results = 1'b1;

			sent = 0;
			while (sent < PH_ITEMS[p]) begin
				if (plan.size() == 0) begin
					case ($urandom_range(0, 9))
						0, 1, 2, 3, 4: begin
							frame = {1'b1, 8'($urandom), 1'b0};
							// broken frame: stop bit held low
							if ($urandom_range(0, 5) == 0)
								frame[9] = 1'b0;
							repeat ($urandom_range(1, 3))
								plan.push_back(line_tick(1'b1, 1'b0, 8'($urandom), 1'($urandom)));
							for (int i = 0; i < 10; i++)
								repeat (rx_span)
									plan.push_back(line_tick(frame[i],
										$urandom_range(0, 15) == 0,
										8'($urandom), 1'($urandom)));
						end
						5, 6, 7: begin
							burst = $urandom_range(1, 3);
							for (int i = 0; i < burst; i++) begin
								plan.push_back(line_tick(1'b1, 1'b1, 8'($urandom),
									i == burst - 1 && $urandom_range(0, 3) != 0));
								// ride out the frame, then leave a short gap
								repeat (10 * tx_span + $urandom_range(0, 2))
									plan.push_back(line_tick($urandom_range(0, 7) != 0,
										$urandom_range(0, 31) == 0,
										8'($urandom), 1'($urandom)));
							end
						end
						default: begin
							repeat ($urandom_range(1, 16))
								plan.push_back(line_tick(1'($urandom),
									$urandom_range(0, 3) == 0,
									8'($urandom), 1'($urandom)));
						end
					endcase
				end
				item = plan.pop_front();
				if ($urandom_range(0, 31) == 0)
					tx_quiet = !tx_quiet;
				gap = tx_quiet ? 0 : $urandom_range(0, 15);
				if (gap > 0) begin
					tick_ch.valid <= 1'b0;
					repeat (gap) @(negedge clk);
				end
				tick_ch.payload <= item;
				tick_ch.valid   <= 1'b1;
				do @(posedge clk); while (!tick_ch.ready);
				@(negedge clk);
				sent++;
				// pause mid-phase until every result is back
				if (sent == PH_ITEMS[p] / 2) begin
					tick_ch.valid <= 1'b0;
					wait_drained();
				end
			end
			plan.delete();
			tick_ch.valid <= 1'b0;
			wait_drained();
			repeat (4) @(negedge clk);
		end

		if (fail_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
